@@ design/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int NUM_LIMIT       = 10;

  typedef enum logic [2:0] {
    MODE_NUM = 3'd0,
    MODE_ADD = 3'd1,
    MODE_SUB = 3'd2,
    MODE_MUL = 3'd3,
    MODE_DIV = 3'd4,
    MODE_END = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_COUNT    = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

@@ design/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish notation calculator over a stack of 32-bit operands.
// ----------------------------------------------------------------------------
// Each input item carries one token: a number, an operator (add, subtract,
// multiply, divide) or an end-of-expression marker. Every item gives exactly
// one result item with a status, the answer on a good end marker, a flag that
// marks the close of an expression and the stack depth after the item.
// Both channels use a valid and stall handshake; an item moves on a rising
// edge where valid is high and stall is low.
// An item is worked on alone: in_stall is high from the cycle after
// acceptance until its result has been loaded into the output register.
// A number passes through the decode and done states; an operator also
// reads the stack and runs in the ALU, where a divide uses the radix-2
// divider with one quotient bit per cycle. An end marker reads the stack.
// The result waits in an output register, so a stalled receiver holds back
// the next result only; the next item is still accepted and worked on.
// Synchronous reset empties the stack and drops any pending result; the
// stack memory itself is not cleared, since only entries below the count
// are ever read.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        mode,
  input  logic signed [rse_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic signed [rse_pkg::DATA_W-1:0] answer,
  output logic                              finished,
  output logic [4:0]                        depth_now
);
  import rse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_DONE
  } state_t;

  state_t                   state;
  mode_t                    mode_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            count;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_answer;
  logic                     res_finished;

  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  logic [31:0]              count_wide;
  logic                     in_range;
  logic                     stack_full;
  logic                     load_out;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [DATA_W-1:0]        rd_data_a;
  logic [DATA_W-1:0]        rd_data_b;

  alu_req_t                 alu_req;
  alu_rsp_t                 alu_rsp;
  logic signed [DATA_W-1:0] alu_result;

  assign in_stall   = (state != S_IDLE);
  assign cnt_m1     = count - CW'(1);
  assign cnt_m2     = count - CW'(2);
  assign count_wide = 32'(count);
  // A number must lie below the limit and above the most negative value.
  assign in_range   = (value_q < DATA_W'(NUM_LIMIT)) &&
                      (value_q != {1'b1, {(DATA_W-1){1'b0}}});
  assign stack_full = (count >= CW'(STACK_DEPTH));
  // A finished result moves into the output register once it is free or is
  // being taken by the receiver in the same cycle.
  assign load_out   = (state == S_DONE) && (!out_valid || !out_stall);

  // The write port serves a push while decoding and the write-back of an
  // operator result, which lands on the slot of the lower operand.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = value_q;
    if (state == S_DECODE) begin
      wr_en = (mode_q == MODE_NUM) && in_range && !stack_full;
    end else if (state == S_EXEC) begin
      wr_en   = alu_rsp.done && !alu_rsp.div_zero;
      wr_addr = cnt_m2[AW-1:0];
      wr_data = alu_result;
    end
  end

  always_comb begin
    alu_req.start = (state == S_READ) && (mode_q != MODE_END);
    case (mode_q)
      MODE_ADD: alu_req.op = ALU_ADD;
      MODE_SUB: alu_req.op = ALU_SUB;
      MODE_MUL: alu_req.op = ALU_MUL;
      default:  alu_req.op = ALU_DIV;
    endcase
  end

  // Operand a sits one below the top, operand b on top. On an end marker
  // with a single value the top is entry zero.
  rse_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (cnt_m2[AW-1:0]),
    .rd_addr_b (cnt_m1[AW-1:0]),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  rse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .op_a   ($signed(rd_data_a)),
    .op_b   ($signed(rd_data_b)),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills with a new result, or empties once the
      // receiver takes the item.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q  <= mode_t'(mode);
            value_q <= value;
            state   <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_status   <= ST_OK;
          res_answer   <= '0;
          res_finished <= 1'b0;
          state        <= S_DONE;
          case (mode_q)
            MODE_NUM: begin
              if (!in_range) begin
                res_status   <= ST_RANGE;
                res_finished <= 1'b1;
                count        <= '0;
              end else if (stack_full) begin
                res_status   <= ST_OVERFLOW;
                res_finished <= 1'b1;
                count        <= '0;
              end else begin
                count <= count + CW'(1);
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              if (count < CW'(2)) begin
                res_status   <= ST_FEW;
                res_finished <= 1'b1;
                count        <= '0;
              end else begin
                state <= S_READ;
              end
            end
            MODE_END: begin
              if (count == CW'(1)) begin
                state <= S_READ;
              end else begin
                res_status   <= ST_COUNT;
                res_finished <= 1'b1;
                count        <= '0;
              end
            end
            default: begin
              res_status   <= ST_INVALID;
              res_finished <= 1'b1;
              count        <= '0;
            end
          endcase
        end

        S_READ: begin
          // Read data of the addresses set up while decoding is valid now.
          if (mode_q == MODE_END) begin
            res_answer   <= $signed(rd_data_b);
            res_finished <= 1'b1;
            count        <= '0;
            state        <= S_DONE;
          end else begin
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div_zero) begin
              res_status   <= ST_DIVZERO;
              res_finished <= 1'b1;
              count        <= '0;
            end else begin
              count <= cnt_m1;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (load_out) begin
            status    <= res_status;
            answer    <= res_answer;
            finished  <= res_finished;
            depth_now <= count_wide[4:0];
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/rse_stack.sv @@
// ----------------------------------------------------------------------------
// rse_stack
// Operand stack memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rse_stack #(
  parameter int DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rse_pkg::DATA_W-1:0]  wr_data,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  output logic [rse_pkg::DATA_W-1:0]  rd_data_a,
  output logic [rse_pkg::DATA_W-1:0]  rd_data_b
);
  import rse_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ design/rse_alu.sv @@
// ----------------------------------------------------------------------------
// rse_alu
// Shared arithmetic unit: add, subtract and multiply with a registered result, and a
// radix-2 restoring divider that truncates toward zero.
// ----------------------------------------------------------------------------
module rse_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  rse_pkg::alu_req_t                 req,
  input  logic signed [rse_pkg::DATA_W-1:0] op_a,
  input  logic signed [rse_pkg::DATA_W-1:0] op_b,
  output rse_pkg::alu_rsp_t                 rsp,
  output logic signed [rse_pkg::DATA_W-1:0] result
);
  import rse_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_SIGN
  } alu_state_t;

  alu_state_t        state;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              neg;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W-1:0] trial;
  logic [DATA_W:0]   diff;

  assign mag_a = op_a[DATA_W-1] ? DATA_W'(-op_a) : DATA_W'(op_a);
  assign mag_b = op_b[DATA_W-1] ? DATA_W'(-op_b) : DATA_W'(op_b);
  assign trial = {rem[DATA_W-2:0], quo[DATA_W-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= A_IDLE;
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
    end else begin
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              ALU_ADD: begin
                result   <= op_a + op_b;
                rsp.done <= 1'b1;
              end
              ALU_SUB: begin
                result   <= op_a - op_b;
                rsp.done <= 1'b1;
              end
              ALU_MUL: begin
                result   <= DATA_W'(op_a * op_b);
                rsp.done <= 1'b1;
              end
              default: begin
                if (op_b == '0) begin
                  result       <= '0;
                  rsp.done     <= 1'b1;
                  rsp.div_zero <= 1'b1;
                end else begin
                  quo   <= mag_a;
                  dvs   <= mag_b;
                  rem   <= '0;
                  cnt   <= CNT_W'(DATA_W - 1);
                  neg   <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
                  state <= A_DIV;
                end
              end
            endcase
          end
        end
        A_DIV: begin
          // One quotient bit per cycle, most significant first.
          quo <= {quo[DATA_W-2:0], ~diff[DATA_W]};
          rem <= diff[DATA_W] ? trial : diff[DATA_W-1:0];
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= A_SIGN;
          end
        end
        A_SIGN: begin
          result   <= neg ? -$signed(quo) : $signed(quo);
          rsp.done <= 1'b1;
          state    <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule
